// ----- rtl/impq_pkg.sv -----
`timescale 1ns / 1ps
// Package for the indexed min priority queue: sizes, operation codes,
// heap entry type and the command/status types between controller and datapath.
// No dependencies.
package impq_pkg;

   localparam int CAPACITY = 64;
   localparam int ITEMS    = 64;
   localparam int ITEM_W   = 6;
   localparam int KEY_W    = 32;
   localparam int FUNC_W   = 3;
   localparam int SLOT_W   = $clog2(CAPACITY + 1);
   localparam int ADDR_W   = $clog2(CAPACITY);

   localparam logic [FUNC_W-1:0] FN_QUERY   = 3'd0;
   localparam logic [FUNC_W-1:0] FN_INSERT  = 3'd1;
   localparam logic [FUNC_W-1:0] FN_DEC     = 3'd2;
   localparam logic [FUNC_W-1:0] FN_INC     = 3'd3;
   localparam logic [FUNC_W-1:0] FN_CHANGE  = 3'd4;
   localparam logic [FUNC_W-1:0] FN_DELMIN  = 3'd5;
   localparam logic [FUNC_W-1:0] FN_DELITEM = 3'd6;

   typedef struct packed {
      logic [ITEM_W-1:0]       item;
      logic signed [KEY_W-1:0] key;
   } ent_type;

   typedef enum logic [3:0] {
      STEP_IDLE,
      STEP_RD_POS,
      STEP_RD_ENT,
      STEP_CHECK,
      STEP_UP_RD,
      STEP_UP_CMP,
      STEP_DN_RD,
      STEP_DN_CMP,
      STEP_PLACE,
      STEP_FIN_POS,
      STEP_FIN_ENT,
      STEP_FIN_OUT
   } step_type;

   typedef enum logic [1:0] {
      PATH_FIN,
      PATH_UP,
      PATH_DN
   } path_type;

   typedef struct packed {
      path_type path;
      logic     need_down;
      logic     up_stop;
      logic     dn_stop;
      logic     out_free;
   } stat_type;

endpackage

// ----- rtl/impq_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer for the priority queue: walks lookup, check, sift and result steps.
// Depends on impq_pkg.
module impq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  impq_pkg::stat_type stat,
   output impq_pkg::step_type step,
   output logic               req_stall
);

   typedef enum logic [3:0] {
      S_IDLE, S_RD_POS, S_RD_ENT, S_CHECK, S_UP_RD, S_UP_CMP,
      S_DN_RD, S_DN_CMP, S_PLACE, S_FIN_POS, S_FIN_ENT, S_FIN_OUT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:    if (req_valid) state_in = S_RD_POS;
         S_RD_POS:  state_in = S_RD_ENT;
         S_RD_ENT:  state_in = S_CHECK;
         S_CHECK: begin
            unique case (stat.path)
               impq_pkg::PATH_UP: state_in = S_UP_RD;
               impq_pkg::PATH_DN: state_in = S_DN_RD;
               default:           state_in = S_FIN_POS;
            endcase
         end
         S_UP_RD, S_UP_CMP: begin
            if (stat.up_stop) state_in = stat.need_down ? S_DN_RD : S_PLACE;
            else              state_in = (state_ff == S_UP_RD) ? S_UP_CMP : S_UP_RD;
         end
         S_DN_RD, S_DN_CMP: begin
            if (stat.dn_stop) state_in = S_PLACE;
            else              state_in = (state_ff == S_DN_RD) ? S_DN_CMP : S_DN_RD;
         end
         S_PLACE:   state_in = S_FIN_POS;
         S_FIN_POS: state_in = S_FIN_ENT;
         S_FIN_ENT: state_in = S_FIN_OUT;
         S_FIN_OUT: if (stat.out_free) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      unique case (state_ff)
         S_RD_POS:  step = impq_pkg::STEP_RD_POS;
         S_RD_ENT:  step = impq_pkg::STEP_RD_ENT;
         S_CHECK:   step = impq_pkg::STEP_CHECK;
         S_UP_RD:   step = impq_pkg::STEP_UP_RD;
         S_UP_CMP:  step = impq_pkg::STEP_UP_CMP;
         S_DN_RD:   step = impq_pkg::STEP_DN_RD;
         S_DN_CMP:  step = impq_pkg::STEP_DN_CMP;
         S_PLACE:   step = impq_pkg::STEP_PLACE;
         S_FIN_POS: step = impq_pkg::STEP_FIN_POS;
         S_FIN_ENT: step = impq_pkg::STEP_FIN_ENT;
         S_FIN_OUT: step = impq_pkg::STEP_FIN_OUT;
         default:   step = impq_pkg::STEP_IDLE;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

// ----- rtl/impq_dp.sv -----
`timescale 1ns / 1ps
// Datapath for the priority queue: heap and position memories, sift registers,
// operation checks and the result register. Depends on impq_pkg.
module impq_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  impq_pkg::step_type                   step,
   output impq_pkg::stat_type                   stat,
   input  logic                                 req_valid,
   input  logic [impq_pkg::FUNC_W-1:0]          req_func,
   input  logic [impq_pkg::ITEM_W-1:0]          req_item_index,
   input  logic signed [impq_pkg::KEY_W-1:0]    req_key,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_status,
   output logic [impq_pkg::ITEM_W-1:0]          rsp_popped_index,
   output logic [impq_pkg::ITEM_W-1:0]          rsp_min_index,
   output logic signed [impq_pkg::KEY_W-1:0]    rsp_min_key,
   output logic [impq_pkg::SLOT_W-1:0]          rsp_count,
   output logic                                 rsp_is_empty,
   output logic                                 rsp_present,
   output logic signed [impq_pkg::KEY_W-1:0]    rsp_item_key
);

   localparam int SW = impq_pkg::SLOT_W;
   localparam int AW = impq_pkg::ADDR_W;

   impq_pkg::ent_type heap_mem [impq_pkg::CAPACITY];
   logic [SW-1:0]     pos_mem  [impq_pkg::ITEMS];

   logic [impq_pkg::FUNC_W-1:0]       func_ff;
   logic [impq_pkg::ITEM_W-1:0]       item_ff;
   logic signed [impq_pkg::KEY_W-1:0] key_ff;
   logic [SW-1:0]                     k_ff, k_in;
   logic [SW-1:0]                     count_ff, count_in;
   impq_pkg::ent_type                 e_ff, e_in;
   logic [impq_pkg::ITEMS-1:0]        valid_ff, valid_in;
   logic [impq_pkg::ITEM_W-1:0]       popped_ff, popped_in;
   logic                              refused_ff, refused_in;
   impq_pkg::ent_type                 rd_a_ff, rd_b_ff;
   logic [SW-1:0]                     pos_rd_ff;
   logic                              rsp_valid_ff;

   logic [SW:0]             slot_a, slot_b, slot_a_m1, slot_b_m1, k_dbl;
   logic [AW-1:0]           addr_a, addr_b;
   logic                    heap_we, pos_we;
   logic [AW-1:0]           heap_waddr;
   impq_pkg::ent_type       heap_wdata;
   logic [impq_pkg::ITEM_W-1:0] pos_waddr;
   logic [SW:0]             k_m1, child_slot;
   logic                    held, refuse, right_ok, take_right, out_load;
   impq_pkg::ent_type       child;
   impq_pkg::path_type      path;

   assign k_dbl      = {k_ff, 1'b0};
   assign k_m1       = {1'b0, k_ff} - 1'b1;
   assign held       = valid_ff[item_ff];
   assign right_ok   = k_dbl < {1'b0, count_ff};
   assign take_right = right_ok && (rd_a_ff.key > rd_b_ff.key);
   assign child      = take_right ? rd_b_ff : rd_a_ff;
   assign child_slot = k_dbl + {{SW{1'b0}}, take_right};

   // read addresses per step
   always_comb begin
      slot_a = {{SW{1'b0}}, 1'b1};
      slot_b = {{SW{1'b0}}, 1'b1};
      unique case (step)
         impq_pkg::STEP_RD_ENT: begin
            slot_a = (func_ff == impq_pkg::FN_DELMIN) ? {{SW{1'b0}}, 1'b1} : {1'b0, pos_rd_ff};
            slot_b = {1'b0, count_ff};
         end
         impq_pkg::STEP_UP_RD:  slot_a = {2'b00, k_ff[SW-1:1]};
         impq_pkg::STEP_DN_RD: begin
            slot_a = k_dbl;
            slot_b = k_dbl + 1'b1;
         end
         impq_pkg::STEP_FIN_ENT, impq_pkg::STEP_FIN_OUT: slot_b = {1'b0, pos_rd_ff};
         default: ;
      endcase
   end

   assign slot_a_m1 = slot_a - 1'b1;
   assign slot_b_m1 = slot_b - 1'b1;
   assign addr_a    = slot_a_m1[AW-1:0];
   assign addr_b    = slot_b_m1[AW-1:0];

   // operation check
   always_comb begin
      refuse = 1'b0;
      path   = impq_pkg::PATH_FIN;
      unique case (func_ff)
         impq_pkg::FN_QUERY:   refuse = 1'b0;
         impq_pkg::FN_INSERT: begin
            refuse = held || (count_ff == SW'(impq_pkg::CAPACITY));
            path   = impq_pkg::PATH_UP;
         end
         impq_pkg::FN_DEC: begin
            refuse = !held || (key_ff > rd_a_ff.key);
            path   = impq_pkg::PATH_UP;
         end
         impq_pkg::FN_INC: begin
            refuse = !held || (key_ff < rd_a_ff.key);
            path   = impq_pkg::PATH_DN;
         end
         impq_pkg::FN_CHANGE: begin
            refuse = !held;
            path   = impq_pkg::PATH_UP;
         end
         impq_pkg::FN_DELMIN: begin
            refuse = (count_ff == '0);
            path   = (count_ff > SW'(1)) ? impq_pkg::PATH_DN : impq_pkg::PATH_FIN;
         end
         impq_pkg::FN_DELITEM: begin
            refuse = !held;
            path   = (pos_rd_ff < count_ff) ? impq_pkg::PATH_UP : impq_pkg::PATH_FIN;
         end
         default: refuse = 1'b1;
      endcase
      if (refuse) path = impq_pkg::PATH_FIN;
   end

   assign out_load = (step == impq_pkg::STEP_FIN_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      stat.path      = path;
      stat.need_down = (func_ff == impq_pkg::FN_CHANGE) || (func_ff == impq_pkg::FN_DELITEM);
      stat.up_stop   = (step == impq_pkg::STEP_UP_RD) ? (k_ff == SW'(1))
                                                      : !(rd_a_ff.key > e_ff.key);
      stat.dn_stop   = (step == impq_pkg::STEP_DN_RD) ? (k_dbl > {1'b0, count_ff})
                                                      : (e_ff.key <= child.key);
      stat.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   // state updates and memory writes
   always_comb begin
      k_in       = k_ff;
      count_in   = count_ff;
      e_in       = e_ff;
      valid_in   = valid_ff;
      popped_in  = popped_ff;
      refused_in = refused_ff;
      heap_we    = 1'b0;
      pos_we     = 1'b0;
      heap_waddr = k_m1[AW-1:0];
      heap_wdata = e_ff;
      pos_waddr  = e_ff.item;
      unique case (step)
         impq_pkg::STEP_CHECK: begin
            refused_in = refuse;
            popped_in  = '0;
            if (!refuse) begin
               unique case (func_ff)
                  impq_pkg::FN_INSERT: begin
                     count_in          = count_ff + 1'b1;
                     k_in              = count_ff + 1'b1;
                     e_in              = '{item: item_ff, key: key_ff};
                     valid_in[item_ff] = 1'b1;
                  end
                  impq_pkg::FN_DEC, impq_pkg::FN_INC, impq_pkg::FN_CHANGE: begin
                     k_in = pos_rd_ff;
                     e_in = '{item: item_ff, key: key_ff};
                  end
                  impq_pkg::FN_DELMIN: begin
                     popped_in               = rd_a_ff.item;
                     count_in                = count_ff - 1'b1;
                     k_in                    = SW'(1);
                     e_in                    = rd_b_ff;
                     valid_in[rd_a_ff.item]  = 1'b0;
                  end
                  impq_pkg::FN_DELITEM: begin
                     count_in          = count_ff - 1'b1;
                     k_in              = pos_rd_ff;
                     e_in              = rd_b_ff;
                     valid_in[item_ff] = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         impq_pkg::STEP_UP_CMP: begin
            if (!stat.up_stop) begin
               heap_we    = 1'b1;
               pos_we     = 1'b1;
               heap_wdata = rd_a_ff;
               pos_waddr  = rd_a_ff.item;
               k_in       = {1'b0, k_ff[SW-1:1]};
            end
         end
         impq_pkg::STEP_DN_CMP: begin
            if (!stat.dn_stop) begin
               heap_we    = 1'b1;
               pos_we     = 1'b1;
               heap_wdata = child;
               pos_waddr  = child.item;
               k_in       = child_slot[SW-1:0];
            end
         end
         impq_pkg::STEP_PLACE: begin
            heap_we = 1'b1;
            pos_we  = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (heap_we) heap_mem[heap_waddr] <= heap_wdata;
      if (pos_we)  pos_mem[pos_waddr]   <= k_ff;
      rd_a_ff   <= heap_mem[addr_a];
      rd_b_ff   <= heap_mem[addr_b];
      pos_rd_ff <= pos_mem[item_ff];
   end

   always_ff @(posedge clock) begin
      if (step == impq_pkg::STEP_IDLE && req_valid) begin
         func_ff <= req_func;
         item_ff <= req_item_index;
         key_ff  <= req_key;
      end
      k_ff       <= k_in;
      e_ff       <= e_in;
      popped_ff  <= popped_in;
      refused_ff <= refused_in;
      if (out_load) begin
         rsp_status       <= refused_ff;
         rsp_popped_index <= popped_ff;
         rsp_min_index    <= (count_ff != '0) ? rd_a_ff.item : '0;
         rsp_min_key      <= (count_ff != '0) ? rd_a_ff.key : '0;
         rsp_count        <= count_ff;
         rsp_is_empty     <= (count_ff == '0);
         rsp_present      <= held;
         rsp_item_key     <= held ? rd_b_ff.key : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= valid_in;
         if (out_load)       rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/indexed_min_priority_queue.sv -----
`timescale 1ns / 1ps
// Top level of the indexed min priority queue: controller plus datapath.
// Depends on impq_pkg, impq_ctrl and impq_dp.
//
//   channel | ports                               | direction
//   req     | req_valid/req_stall, func,item,key   | in
//   rsp     | rsp_valid/rsp_stall, eight fields    | out
//
// One operation at a time. Without a sift it walks lookup, check and result steps;
// a sift adds a read and a compare step per level moved, a read or a read and a
// compare to stop, and a place step that writes the entry.
// Reset clears the count, the presence bits and the result valid; no sweep.
// A new request is taken while a result waits; a stalled result holds the
// next one in its final step.
module indexed_min_priority_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [impq_pkg::FUNC_W-1:0]       req_func,
   input  logic [impq_pkg::ITEM_W-1:0]       req_item_index,
   input  logic signed [impq_pkg::KEY_W-1:0] req_key,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_status,
   output logic [impq_pkg::ITEM_W-1:0]       rsp_popped_index,
   output logic [impq_pkg::ITEM_W-1:0]       rsp_min_index,
   output logic signed [impq_pkg::KEY_W-1:0] rsp_min_key,
   output logic [impq_pkg::SLOT_W-1:0]       rsp_count,
   output logic                              rsp_is_empty,
   output logic                              rsp_present,
   output logic signed [impq_pkg::KEY_W-1:0] rsp_item_key
);

   impq_pkg::step_type step;
   impq_pkg::stat_type stat;

   impq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .step      (step),
      .req_stall (req_stall)
   );

   impq_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .stat             (stat),
      .req_valid        (req_valid),
      .req_func         (req_func),
      .req_item_index   (req_item_index),
      .req_key          (req_key),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_popped_index (rsp_popped_index),
      .rsp_min_index    (rsp_min_index),
      .rsp_min_key      (rsp_min_key),
      .rsp_count        (rsp_count),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_present      (rsp_present),
      .rsp_item_key     (rsp_item_key)
   );

endmodule

// ----- rtl/impq_chk.sv -----
`timescale 1ns / 1ps
// Port checker for the indexed min priority queue, bound to the top level.
// Depends on impq_pkg and indexed_min_priority_queue.
module impq_chk (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic                              rsp_status,
   input logic [impq_pkg::ITEM_W-1:0]       rsp_popped_index,
   input logic [impq_pkg::ITEM_W-1:0]       rsp_min_index,
   input logic signed [impq_pkg::KEY_W-1:0] rsp_min_key,
   input logic [impq_pkg::SLOT_W-1:0]       rsp_count,
   input logic                              rsp_is_empty,
   input logic                              rsp_present,
   input logic signed [impq_pkg::KEY_W-1:0] rsp_item_key
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_count == '0)))
      else $error("empty flag disagrees with count");

   a_min_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> (rsp_min_index == '0) && (rsp_min_key == '0))
      else $error("minimum reported on empty queue");

   a_absent_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_present |-> (rsp_item_key == '0))
      else $error("key reported for absent item");

   a_refused_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> (rsp_popped_index == '0))
      else $error("refused transfer reports a popped item");

endmodule

bind indexed_min_priority_queue impq_chk u_impq_chk (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_popped_index (rsp_popped_index),
   .rsp_min_index    (rsp_min_index),
   .rsp_min_key      (rsp_min_key),
   .rsp_count        (rsp_count),
   .rsp_is_empty     (rsp_is_empty),
   .rsp_present      (rsp_present),
   .rsp_item_key     (rsp_item_key)
);

// ----- verif/tb_indexed_min_priority_queue.sv -----
`timescale 1ns / 1ps
// Self-checking bench for indexed_min_priority_queue: a directed table and a
// random operation mix, checked against a heap predictor held in this file.
// Depends on impq_pkg and the queue RTL.
module tb_indexed_min_priority_queue;

   localparam int IW  = impq_pkg::ITEM_W;
   localparam int KW  = impq_pkg::KEY_W;
   localparam int SW  = impq_pkg::SLOT_W;
   localparam int FW  = impq_pkg::FUNC_W;
   localparam int CAP = impq_pkg::CAPACITY;
   localparam int NI  = impq_pkg::ITEMS;
   localparam logic [FW-1:0] FN_RSVD = 3'd7;

   typedef struct packed {
      logic                 status;
      logic [IW-1:0]        popped;
      logic [IW-1:0]        min_idx;
      logic signed [KW-1:0] min_key;
      logic [SW-1:0]        cnt;
      logic                 empty;
      logic                 present;
      logic signed [KW-1:0] item_key;
   } answer_type;

   typedef struct {
      logic [FW-1:0]        fn;
      logic [IW-1:0]        idx;
      logic signed [KW-1:0] key;
      logic                 fixed;
      answer_type           ans;
   } row_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [FW-1:0]               req_func = '0;
   logic [IW-1:0]               req_item_index = '0;
   logic signed [KW-1:0]        req_key = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic                        rsp_status;
   logic [IW-1:0]               rsp_popped_index;
   logic [IW-1:0]               rsp_min_index;
   logic signed [KW-1:0]        rsp_min_key;
   logic [SW-1:0]               rsp_count;
   logic                        rsp_is_empty;
   logic                        rsp_present;
   logic signed [KW-1:0]        rsp_item_key;

   // heap predictor state
   logic [IW-1:0]        hp_slot [1:CAP];
   int unsigned          hp_pos  [0:NI-1];
   logic signed [KW-1:0] hp_key  [0:NI-1];
   int unsigned          hp_cnt;

   answer_type answer_q[$];
   row_type    row_q[$];
   int         errors = 0;
   int         cycles = 0;
   bit         sending_done = 1'b0;
   bit         quiet = 1'b0;

   indexed_min_priority_queue u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_item_index   (req_item_index),
      .req_key          (req_key),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_popped_index (rsp_popped_index),
      .rsp_min_index    (rsp_min_index),
      .rsp_min_key      (rsp_min_key),
      .rsp_count        (rsp_count),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_present      (rsp_present),
      .rsp_item_key     (rsp_item_key)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic logic signed [KW-1:0] key_of(int unsigned s);
      return hp_key[hp_slot[s]];
   endfunction

   function automatic void trade(int unsigned a, int unsigned b);
      logic [IW-1:0] t;
      t = hp_slot[a];
      hp_slot[a] = hp_slot[b];
      hp_slot[b] = t;
      hp_pos[hp_slot[a]] = a;
      hp_pos[hp_slot[b]] = b;
   endfunction

   function automatic void rise(int unsigned k);
      while (k > 1 && key_of(k / 2) > key_of(k)) begin
         trade(k, k / 2);
         k = k / 2;
      end
   endfunction

   function automatic void sink(int unsigned k);
      int unsigned c;
      while (2 * k <= hp_cnt) begin
         c = 2 * k;
         if (c < hp_cnt && key_of(c) > key_of(c + 1)) c++;
         if (key_of(k) <= key_of(c)) break;
         trade(k, c);
         k = c;
      end
   endfunction

   function automatic answer_type apply_op(logic [FW-1:0] fn, logic [IW-1:0] idx,
                                           logic signed [KW-1:0] key);
      answer_type  a;
      bit          held;
      int unsigned s;
      a = '0;
      held = hp_pos[idx] != 0;
      case (fn)
         impq_pkg::FN_QUERY: ;
         impq_pkg::FN_INSERT: begin
            if (held || hp_cnt >= CAP) a.status = 1'b1;
            else begin
               hp_cnt++;
               hp_pos[idx] = hp_cnt;
               hp_slot[hp_cnt] = idx;
               hp_key[idx] = key;
               rise(hp_cnt);
            end
         end
         impq_pkg::FN_DEC, impq_pkg::FN_INC, impq_pkg::FN_CHANGE: begin
            if (!held || (fn == impq_pkg::FN_DEC && key > hp_key[idx])
                || (fn == impq_pkg::FN_INC && key < hp_key[idx])) a.status = 1'b1;
            else begin
               hp_key[idx] = key;
               if (fn != impq_pkg::FN_INC) rise(hp_pos[idx]);
               if (fn != impq_pkg::FN_DEC) sink(hp_pos[idx]);
            end
         end
         impq_pkg::FN_DELMIN: begin
            if (hp_cnt == 0) a.status = 1'b1;
            else begin
               a.popped = hp_slot[1];
               trade(1, hp_cnt);
               hp_cnt--;
               sink(1);
               hp_pos[a.popped] = 0;
            end
         end
         impq_pkg::FN_DELITEM: begin
            if (!held) a.status = 1'b1;
            else begin
               s = hp_pos[idx];
               trade(s, hp_cnt);
               hp_cnt--;
               if (s <= hp_cnt) begin
                  rise(s);
                  sink(s);
               end
               hp_pos[idx] = 0;
            end
         end
         default: a.status = 1'b1;
      endcase
      if (hp_cnt != 0) begin
         a.min_idx = hp_slot[1];
         a.min_key = key_of(1);
      end
      a.cnt = SW'(hp_cnt);
      a.empty = (hp_cnt == 0);
      if (hp_pos[idx] != 0) begin
         a.present = 1'b1;
         a.item_key = hp_key[idx];
      end
      return a;
   endfunction

   function automatic answer_type done_as(int mi, logic signed [KW-1:0] mk, int c, int st,
                                          int pop, int pr, logic signed [KW-1:0] ik);
      answer_type a;
      a.status = st[0]; a.popped = IW'(pop); a.min_idx = IW'(mi); a.min_key = mk;
      a.cnt = SW'(c); a.empty = (c == 0); a.present = pr[0]; a.item_key = ik;
      return a;
   endfunction

   function automatic void post_answer(answer_type a);
      answer_q = {answer_q, a};
   endfunction

   function automatic void add_row(logic [FW-1:0] fn, int idx,
                                   logic signed [KW-1:0] key, bit fixed,
                                   answer_type ans);
      row_type r;
      r.fn = fn; r.idx = IW'(idx); r.key = key; r.fixed = fixed; r.ans = ans;
      row_q = {row_q, r};
   endfunction

   localparam logic signed [KW-1:0] KMIN = 32'sh8000_0000;
   localparam logic signed [KW-1:0] KMAX = 32'sh7fff_ffff;

   task automatic send(logic [FW-1:0] fn, logic [IW-1:0] idx,
                       logic signed [KW-1:0] key);
      req_func <= fn;
      req_item_index <= idx;
      req_key <= key;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic maybe_idle(bit allow);
      while (allow && !quiet && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   function automatic logic signed [KW-1:0] rand_key();
      case ($urandom_range(3))
         0: return KW'($urandom_range(40) - 20);
         1: return KMIN + KW'($urandom_range(3));
         2: return KMAX - KW'($urandom_range(3));
         default: return KW'($urandom);
      endcase
   endfunction

   // stimulus
   initial begin
      row_type              r;
      answer_type           a;
      logic [FW-1:0]        fn;
      logic [IW-1:0]        idx;
      logic signed [KW-1:0] k;
      int                   n;
      for (int i = 0; i < NI; i++) hp_pos[i] = 0;
      hp_cnt = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      add_row(impq_pkg::FN_QUERY, 0, 0, 1'b1, done_as(0, 0, 0, 0, 0, 0, 0));
      add_row(impq_pkg::FN_DELMIN, 0, 0, 1'b1, done_as(0, 0, 0, 1, 0, 0, 0));
      add_row(impq_pkg::FN_DELITEM, 63, 0, 1'b1, done_as(0, 0, 0, 1, 0, 0, 0));
      add_row(impq_pkg::FN_DEC, 5, 0, 1'b1, done_as(0, 0, 0, 1, 0, 0, 0));
      add_row(FN_RSVD, 0, 0, 1'b1, done_as(0, 0, 0, 1, 0, 0, 0));
      add_row(impq_pkg::FN_INSERT, 63, KMAX, 1'b1, done_as(63, KMAX, 1, 0, 0, 1, KMAX));
      add_row(impq_pkg::FN_INSERT, 0, KMIN, 1'b1, done_as(0, KMIN, 2, 0, 0, 1, KMIN));
      add_row(impq_pkg::FN_INSERT, 0, 5, 1'b1, done_as(0, KMIN, 2, 1, 0, 1, KMIN));
      add_row(impq_pkg::FN_INSERT, 21, -1, 1'b0, '0);
      add_row(impq_pkg::FN_INSERT, 42, -1, 1'b0, '0);
      add_row(impq_pkg::FN_DEC, 63, KMAX, 1'b0, '0);
      add_row(impq_pkg::FN_DEC, 21, 0, 1'b0, '0);
      add_row(impq_pkg::FN_DEC, 21, -5, 1'b0, '0);
      add_row(impq_pkg::FN_INC, 42, -2, 1'b0, '0);
      add_row(impq_pkg::FN_INC, 0, 10, 1'b0, '0);
      add_row(impq_pkg::FN_INC, 0, 10, 1'b0, '0);
      add_row(impq_pkg::FN_CHANGE, 63, KMIN, 1'b0, '0);
      add_row(impq_pkg::FN_CHANGE, 63, KMAX, 1'b0, '0);
      add_row(impq_pkg::FN_DELITEM, 21, 0, 1'b0, '0);
      add_row(impq_pkg::FN_DELMIN, 0, 0, 1'b0, '0);
      add_row(impq_pkg::FN_QUERY, 42, 0, 1'b0, '0);
      add_row(impq_pkg::FN_DELMIN, 0, 0, 1'b0, '0);
      add_row(impq_pkg::FN_DELMIN, 0, 0, 1'b0, '0);
      add_row(impq_pkg::FN_DELMIN, 0, 0, 1'b1, done_as(0, 0, 0, 1, 0, 0, 0));

      foreach (row_q[i]) begin
         r = row_q[i];
         a = apply_op(r.fn, r.idx, r.key);
         post_answer(r.fixed ? r.ans : a);
         send(r.fn, r.idx, r.key);
      end

      n = 0;
      while (n < 900) begin
         maybe_idle(1'b1);
         // inserts, then a mix biased toward held items and a delete-min run
         if (n < 70) fn = impq_pkg::FN_INSERT;
         else if (n >= 200 && n < 280) fn = impq_pkg::FN_DELMIN;
         else if ($urandom_range(99) < 3) fn = FN_RSVD;
         else fn = FW'($urandom_range(6));
         idx = IW'($urandom_range(NI - 1));
         if (fn != impq_pkg::FN_INSERT && hp_cnt != 0 && $urandom_range(3) != 0)
            idx = hp_slot[$urandom_range(hp_cnt, 1)];
         k = rand_key();
         a = apply_op(fn, idx, k);
         post_answer(a);
         send(fn, idx, k);
         n++;
      end
      req_valid <= 1'b0;
      sending_done = 1'b1;
   end

   // receiver stall pattern
   initial begin
      int span;
      @(negedge reset);
      repeat (300) @(posedge clock);
      rsp_stall <= 1'b1;
      for (span = 0; span < 200; span++) @(posedge clock);
      rsp_stall <= 1'b0;
      quiet = 1'b1;
      repeat (3000) @(posedge clock);
      quiet = 1'b0;
      forever begin
         @(posedge clock);
         rsp_stall <= $urandom_range(99) < 20;
      end
   end

   always @(posedge clock) begin
      answer_type e, g;
      if (!reset && rsp_valid && !rsp_stall) begin
         g = {rsp_status, rsp_popped_index, rsp_min_index, rsp_min_key, rsp_count,
              rsp_is_empty, rsp_present, rsp_item_key};
         if (answer_q.size() == 0) begin
            $display("%0t unexpected transfer %h", $realtime, g);
            errors++;
         end else begin
            e = answer_q.pop_front();
            if (e !== g) begin
               $display("%0t expected st=%0d pop=%0d min=%0d/%0d cnt=%0d emp=%0d pr=%0d k=%0d",
                        $realtime, e.status, e.popped, e.min_idx, e.min_key, e.cnt,
                        e.empty, e.present, e.item_key);
               $display("%0t actual   st=%0d pop=%0d min=%0d/%0d cnt=%0d emp=%0d pr=%0d k=%0d",
                        $realtime, g.status, g.popped, g.min_idx, g.min_key, g.cnt,
                        g.empty, g.present, g.item_key);
               errors++;
            end
         end
      end
   end

   initial begin
      wait (sending_done);
      while (answer_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule
